// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// When ante holds, cons must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/pps_pkg.sv =====
`timescale 1ns / 1ps

package pps_pkg;

    // Fixed field widths
    localparam int ARR_W   = 16;
    localparam int BURST_W = 16;
    localparam int PRIO_W  = 8;
    localparam int PID_W   = 5;
    localparam int RES_W   = 21;

    // Sequencer states
    typedef enum logic [2:0] {
        S_LOAD,
        S_SCAN,
        S_UPD,
        S_OUT_RD,
        S_OUT_WR
    } t_state;

    // Controls from the sequencer to the scan unit
    typedef struct packed {
        logic clear;
        logic eval;
    } t_scan_ctl;

endpackage

// ===== rtl/core/priority_preemptive_scheduler.sv =====
`timescale 1ns / 1ps
// Preemptive priority scheduler.
// Input channel (i_valid/o_ready) takes one process record per beat: arrival,
// burst, priority and a last-record flag. Records load one per cycle into a
// table of MAX_PROCS entries; records beyond that are dropped.
// The beat with last_record set starts the run. The block drops o_ready and
// steps through scheduling decisions: each one scans the table (one entry a
// cycle through the registered read port) and then applies the decision in
// S_UPD. A decision either finishes a process, stops at the next arrival or
// idles forward, so a run takes at most about 3n decisions for n records.
// Results then leave on the output channel (o_valid/i_ready) in load order:
// each is read from the table (S_OUT_RD), then loaded into the output
// register (S_OUT_WR); the last one carries o_last_result. A stalled receiver
// holds the output register and the sequencer waits; the next batch can start
// loading while the final result still waits to be taken.
// Reset (synchronous, active low) empties the table and returns to loading;
// the record memories need no clearing pass.
`include "assert_macros.svh"

module priority_preemptive_scheduler #(
    parameter int MAX_PROCS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [pps_pkg::ARR_W-1:0]     i_arrival_time,
    input  logic [pps_pkg::BURST_W-1:0]   i_burst_length,
    input  logic [pps_pkg::PRIO_W-1:0]    i_priority_level,
    input  logic                          i_last_record,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [pps_pkg::PID_W-1:0]     o_process_id,
    output logic [pps_pkg::RES_W-1:0]     o_turnaround,
    output logic [pps_pkg::RES_W-1:0]     o_response,
    output logic [pps_pkg::RES_W-1:0]     o_waiting,
    output logic                          o_last_result
);
    import pps_pkg::*;

    localparam int IDX_W  = $clog2(MAX_PROCS);
    localparam int CNT_W  = $clog2(MAX_PROCS + 1);
    localparam int TIME_W = 17 + IDX_W;
    localparam int WIDE_W = (TIME_W > RES_W) ? TIME_W : RES_W;
    localparam int PIDW_W = (CNT_W > PID_W) ? CNT_W : PID_W;

    t_state n_state;
    t_state r_state;

    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_idx;
    logic [CNT_W-1:0]    r_pidx;
    logic                r_pv;
    logic [TIME_W-1:0]   r_tick;
    logic [CNT_W-1:0]    r_done;
    logic [MAX_PROCS-1:0] r_started;

    logic                r_out_vld;
    logic [PID_W-1:0]    r_out_pid;
    logic [RES_W-1:0]    r_out_tat;
    logic [RES_W-1:0]    r_out_rsp;
    logic [RES_W-1:0]    r_out_wt;
    logic                r_out_last;

    // Sequencer outputs
    logic      w_in_acc;
    logic      w_store;
    logic      w_issue;
    logic      w_st_we;
    logic      w_dy_we;
    logic      w_out_load;
    t_scan_ctl w_scan_ctl;

    // Table read data
    logic [ARR_W-1:0]   w_rd_arr;
    logic [BURST_W-1:0] w_rd_burst;
    logic [PRIO_W-1:0]  w_rd_prio;
    logic [BURST_W-1:0] w_rd_rem;
    logic [TIME_W-1:0]  w_rd_first;
    logic [TIME_W-1:0]  w_rd_finish;

    // Table write data
    logic [IDX_W-1:0]   w_wr_addr;
    logic [BURST_W-1:0] w_ld_burst;
    logic [BURST_W-1:0] w_wr_rem;
    logic [TIME_W-1:0]  w_wr_first;
    logic [TIME_W-1:0]  w_wr_finish;

    // Scan results
    logic               w_have_best;
    logic [IDX_W-1:0]   w_best_idx;
    logic [BURST_W-1:0] w_best_rem;
    logic [TIME_W-1:0]  w_best_first;
    logic [TIME_W-1:0]  w_best_finish;
    logic               w_have_next;
    logic [ARR_W-1:0]   w_next_arr;

    // Dispatch update
    logic [TIME_W-1:0]  w_next_ext;
    logic [TIME_W-1:0]  w_end;
    logic [TIME_W-1:0]  w_stop;
    logic [TIME_W-1:0]  w_delta;
    logic [BURST_W-1:0] w_rem_new;
    logic               w_fin;
    logic               w_batch_done;
    logic [CNT_W-1:0]   w_last_idx;

    // Result arithmetic
    logic [WIDE_W-1:0]  w_tat;
    logic [WIDE_W-1:0]  w_rsp;
    logic [WIDE_W-1:0]  w_wt;
    logic [PIDW_W-1:0]  w_pid;

    pps_table #(
        .MAX_PROCS (MAX_PROCS),
        .TIME_W    (TIME_W)
    ) u_table (
        .i_clk        (i_clk),
        .i_st_we      (w_st_we),
        .i_dy_we      (w_dy_we),
        .i_wr_addr    (w_wr_addr),
        .i_wr_arrival (i_arrival_time),
        .i_wr_burst   (w_ld_burst),
        .i_wr_prio    (i_priority_level),
        .i_wr_rem     (w_wr_rem),
        .i_wr_first   (w_wr_first),
        .i_wr_finish  (w_wr_finish),
        .i_rd_addr    (r_idx[IDX_W-1:0]),
        .o_rd_arrival (w_rd_arr),
        .o_rd_burst   (w_rd_burst),
        .o_rd_prio    (w_rd_prio),
        .o_rd_rem     (w_rd_rem),
        .o_rd_first   (w_rd_first),
        .o_rd_finish  (w_rd_finish)
    );

    pps_scan #(
        .MAX_PROCS (MAX_PROCS),
        .TIME_W    (TIME_W)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_scan_ctl),
        .i_idx         (r_pidx[IDX_W-1:0]),
        .i_tick        (r_tick),
        .i_arrival     (w_rd_arr),
        .i_prio        (w_rd_prio),
        .i_rem         (w_rd_rem),
        .i_first       (w_rd_first),
        .i_finish      (w_rd_finish),
        .o_have_best   (w_have_best),
        .o_best_idx    (w_best_idx),
        .o_best_rem    (w_best_rem),
        .o_best_first  (w_best_first),
        .o_best_finish (w_best_finish),
        .o_have_next   (w_have_next),
        .o_next_arr    (w_next_arr)
    );

    // Dispatch: run the chosen process until it ends or the next arrival
    always_comb begin
        w_last_idx   = r_count - CNT_W'(1);
        w_next_ext   = {{(TIME_W-ARR_W){1'b0}}, w_next_arr};
        w_end        = r_tick + {{(TIME_W-BURST_W){1'b0}}, w_best_rem};
        w_stop       = (w_have_next && (w_next_ext < w_end)) ? w_next_ext : w_end;
        w_delta      = w_stop - r_tick;
        w_rem_new    = w_best_rem - w_delta[BURST_W-1:0];
        w_fin        = w_have_best && (w_rem_new == '0);
        w_batch_done = w_fin && ((r_done + CNT_W'(1)) == r_count);
    end

    // Table write mux: load writes the new record, update writes progress
    always_comb begin
        w_ld_burst = (i_burst_length == '0) ? BURST_W'(1) : i_burst_length;
        if (r_state == S_LOAD) begin
            w_wr_addr   = r_count[IDX_W-1:0];
            w_wr_rem    = w_ld_burst;
            w_wr_first  = '0;
            w_wr_finish = '0;
        end else begin
            w_wr_addr   = w_best_idx;
            w_wr_rem    = w_rem_new;
            w_wr_first  = r_started[w_best_idx] ? w_best_first : r_tick;
            w_wr_finish = (w_rem_new == '0) ? w_stop : w_best_finish;
        end
    end

    // Result arithmetic, reported modulo 2^21
    always_comb begin
        w_tat = WIDE_W'(w_rd_finish) - WIDE_W'(w_rd_arr);
        w_rsp = WIDE_W'(w_rd_first) - WIDE_W'(w_rd_arr);
        w_wt  = w_tat - WIDE_W'(w_rd_burst);
        w_pid = PIDW_W'(r_idx) + PIDW_W'(1);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (i_valid && i_last_record) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_pv && (r_pidx == w_last_idx)) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_state = w_batch_done ? S_OUT_RD : S_SCAN;
            end
            S_OUT_RD: begin
                n_state = S_OUT_WR;
            end
            S_OUT_WR: begin
                if (w_out_load) begin
                    n_state = (r_idx == w_last_idx) ? S_LOAD : S_OUT_RD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_ready          = 1'b0;
        w_issue          = 1'b0;
        w_out_load       = 1'b0;
        w_dy_we          = 1'b0;
        w_scan_ctl.clear = 1'b0;
        w_scan_ctl.eval  = r_pv;
        case (r_state)
            S_LOAD: begin
                o_ready          = 1'b1;
                w_scan_ctl.clear = i_valid && i_last_record;
            end
            S_SCAN: begin
                w_issue = (r_idx < r_count);
            end
            S_UPD: begin
                w_dy_we          = w_have_best;
                w_scan_ctl.clear = 1'b1;
            end
            S_OUT_RD: begin
            end
            S_OUT_WR: begin
                w_out_load = !r_out_vld || i_ready;
            end
            default: begin
            end
        endcase
        w_in_acc = i_valid && o_ready;
        w_store  = w_in_acc && (r_count < CNT_W'(MAX_PROCS));
        w_st_we  = w_store;
        w_dy_we  = w_dy_we || w_store;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_count   <= '0;
            r_idx     <= '0;
            r_pidx    <= '0;
            r_pv      <= 1'b0;
            r_tick    <= '0;
            r_done    <= '0;
            r_started <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pv    <= w_issue;
            r_pidx  <= r_idx;

            if (w_store) begin
                r_count <= r_count + CNT_W'(1);
            end

            // Batch start
            if (w_in_acc && i_last_record) begin
                r_idx     <= '0;
                r_tick    <= '0;
                r_done    <= '0;
                r_started <= '0;
            end

            if (w_issue) begin
                r_idx <= r_idx + CNT_W'(1);
            end

            // Decision update
            if (r_state == S_UPD) begin
                r_idx  <= '0;
                r_tick <= w_have_best ? w_stop : w_next_ext;
                if (w_have_best) begin
                    r_started[w_best_idx] <= 1'b1;
                end
                if (w_fin) begin
                    r_done <= r_done + CNT_W'(1);
                end
            end

            // Result beat loaded; last one closes the batch
            if (w_out_load) begin
                if (r_idx == w_last_idx) begin
                    r_idx     <= '0;
                    r_count   <= '0;
                    r_tick    <= '0;
                    r_done    <= '0;
                    r_started <= '0;
                end else begin
                    r_idx <= r_idx + CNT_W'(1);
                end
            end

            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Output payload register
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_pid  <= w_pid[PID_W-1:0];
            r_out_tat  <= w_tat[RES_W-1:0];
            r_out_rsp  <= w_rsp[RES_W-1:0];
            r_out_wt   <= w_wt[RES_W-1:0];
            r_out_last <= (r_idx == w_last_idx);
        end
    end

    assign o_valid       = r_out_vld;
    assign o_process_id  = r_out_pid;
    assign o_turnaround  = r_out_tat;
    assign o_response    = r_out_rsp;
    assign o_waiting     = r_out_wt;
    assign o_last_result = r_out_last;

    // Checks
    `ASSERT_ALWAYS(a_count_max, i_clk, i_rst_n, r_count <= CNT_W'(MAX_PROCS))
    `ASSERT_ALWAYS(a_done_max, i_clk, i_rst_n, r_done <= r_count)
    `ASSERT_ALWAYS(a_upd_live, i_clk, i_rst_n, !(r_state == S_UPD && w_have_best) || (w_best_rem != '0))
    `ASSERT_NEXT(a_batch_end, i_clk, i_rst_n, r_state == S_OUT_WR && n_state == S_LOAD, r_count == '0 && r_started == '0)

endmodule

// ===== rtl/core/pps_table.sv =====
`timescale 1ns / 1ps

module pps_table #(
    parameter int MAX_PROCS = 16,
    parameter int TIME_W    = 21
) (
    input  logic                               i_clk,
    input  logic                               i_st_we,
    input  logic                               i_dy_we,
    input  logic [$clog2(MAX_PROCS)-1:0]       i_wr_addr,
    input  logic [pps_pkg::ARR_W-1:0]          i_wr_arrival,
    input  logic [pps_pkg::BURST_W-1:0]        i_wr_burst,
    input  logic [pps_pkg::PRIO_W-1:0]         i_wr_prio,
    input  logic [pps_pkg::BURST_W-1:0]        i_wr_rem,
    input  logic [TIME_W-1:0]                  i_wr_first,
    input  logic [TIME_W-1:0]                  i_wr_finish,
    input  logic [$clog2(MAX_PROCS)-1:0]       i_rd_addr,
    output logic [pps_pkg::ARR_W-1:0]          o_rd_arrival,
    output logic [pps_pkg::BURST_W-1:0]        o_rd_burst,
    output logic [pps_pkg::PRIO_W-1:0]         o_rd_prio,
    output logic [pps_pkg::BURST_W-1:0]        o_rd_rem,
    output logic [TIME_W-1:0]                  o_rd_first,
    output logic [TIME_W-1:0]                  o_rd_finish
);
    import pps_pkg::*;

    localparam int ST_W = ARR_W + BURST_W + PRIO_W;
    localparam int DY_W = BURST_W + 2 * TIME_W;

    // Static record: arrival, burst, priority; written on load only
    logic [ST_W-1:0] r_st_mem [MAX_PROCS];
    // Dynamic record: remaining ticks, first dispatch, completion
    logic [DY_W-1:0] r_dy_mem [MAX_PROCS];
    logic [ST_W-1:0] r_st_q;
    logic [DY_W-1:0] r_dy_q;

    // Write ports
    always_ff @(posedge i_clk) begin
        if (i_st_we) begin
            r_st_mem[i_wr_addr] <= {i_wr_arrival, i_wr_burst, i_wr_prio};
        end
        if (i_dy_we) begin
            r_dy_mem[i_wr_addr] <= {i_wr_rem, i_wr_first, i_wr_finish};
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_st_q <= r_st_mem[i_rd_addr];
        r_dy_q <= r_dy_mem[i_rd_addr];
    end

    assign o_rd_arrival = r_st_q[ST_W-1 -: ARR_W];
    assign o_rd_burst   = r_st_q[PRIO_W +: BURST_W];
    assign o_rd_prio    = r_st_q[PRIO_W-1:0];
    assign o_rd_rem     = r_dy_q[DY_W-1 -: BURST_W];
    assign o_rd_first   = r_dy_q[TIME_W +: TIME_W];
    assign o_rd_finish  = r_dy_q[TIME_W-1:0];

endmodule

// ===== rtl/core/pps_scan.sv =====
`timescale 1ns / 1ps

module pps_scan #(
    parameter int MAX_PROCS = 16,
    parameter int TIME_W    = 21
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pps_pkg::t_scan_ctl                 i_ctl,
    input  logic [$clog2(MAX_PROCS)-1:0]       i_idx,
    input  logic [TIME_W-1:0]                  i_tick,
    input  logic [pps_pkg::ARR_W-1:0]          i_arrival,
    input  logic [pps_pkg::PRIO_W-1:0]         i_prio,
    input  logic [pps_pkg::BURST_W-1:0]        i_rem,
    input  logic [TIME_W-1:0]                  i_first,
    input  logic [TIME_W-1:0]                  i_finish,
    output logic                               o_have_best,
    output logic [$clog2(MAX_PROCS)-1:0]       o_best_idx,
    output logic [pps_pkg::BURST_W-1:0]        o_best_rem,
    output logic [TIME_W-1:0]                  o_best_first,
    output logic [TIME_W-1:0]                  o_best_finish,
    output logic                               o_have_next,
    output logic [pps_pkg::ARR_W-1:0]          o_next_arr
);
    import pps_pkg::*;

    localparam int IDX_W = $clog2(MAX_PROCS);

    logic               r_have_best;
    logic               r_have_next;
    logic [IDX_W-1:0]   r_best_idx;
    logic [PRIO_W-1:0]  r_best_prio;
    logic [BURST_W-1:0] r_best_rem;
    logic [TIME_W-1:0]  r_best_first;
    logic [TIME_W-1:0]  r_best_finish;
    logic [ARR_W-1:0]   r_next_arr;

    logic w_live;
    logic w_arrived;
    logic w_take_best;
    logic w_take_next;

    // One entry per beat: arrived test, priority compare, next-arrival compare
    always_comb begin
        w_live      = (i_rem != '0);
        w_arrived   = ({{(TIME_W-ARR_W){1'b0}}, i_arrival} <= i_tick);
        w_take_best = i_ctl.eval && w_live && w_arrived &&
                      (!r_have_best || (i_prio < r_best_prio));
        w_take_next = i_ctl.eval && w_live && !w_arrived &&
                      (!r_have_next || (i_arrival < r_next_arr));
    end

    // Found flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_best <= 1'b0;
            r_have_next <= 1'b0;
        end else if (i_ctl.clear) begin
            r_have_best <= 1'b0;
            r_have_next <= 1'b0;
        end else begin
            if (w_take_best) begin
                r_have_best <= 1'b1;
            end
            if (w_take_next) begin
                r_have_next <= 1'b1;
            end
        end
    end

    // Captured candidates
    always_ff @(posedge i_clk) begin
        if (w_take_best) begin
            r_best_idx    <= i_idx;
            r_best_prio   <= i_prio;
            r_best_rem    <= i_rem;
            r_best_first  <= i_first;
            r_best_finish <= i_finish;
        end
        if (w_take_next) begin
            r_next_arr <= i_arrival;
        end
    end

    assign o_have_best   = r_have_best;
    assign o_best_idx    = r_best_idx;
    assign o_best_rem    = r_best_rem;
    assign o_best_first  = r_best_first;
    assign o_best_finish = r_best_finish;
    assign o_have_next   = r_have_next;
    assign o_next_arr    = r_next_arr;

endmodule
